// ===== src/gclp_pkg.sv =====
// Shared types, character codes and field codes for the grid command line parser.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package gclp_pkg;

   // Status of the field currently being collected
   typedef struct packed {
      logic        nonempty;
      logic [1:0]  nonspace_count;
      logic [7:0]  first_char;
      logic        negative;
      logic [16:0] magnitude;
   } tok_status_type;

   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_VTAB    = 8'h0B;
   localparam logic [7:0] CHAR_FFEED   = 8'h0C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_ONE     = 8'h31;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOW_A   = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z   = 8'h7A;
   localparam logic [7:0] CHAR_R       = 8'h52;
   localparam logic [7:0] CHAR_W       = 8'h57;
   localparam logic [7:0] CHAR_P       = 8'h50;
   localparam logic [7:0] CHAR_V       = 8'h56;
   localparam logic [7:0] CHAR_I       = 8'h49;

   localparam logic [2:0] FIELD_CMD   = 3'd0;
   localparam logic [2:0] FIELD_SPEC  = 3'd1;
   localparam logic [2:0] FIELD_X     = 3'd2;
   localparam logic [2:0] FIELD_Y     = 3'd3;
   localparam logic [2:0] FIELD_VALUE = 3'd4;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_ALL   = 2'd2;

   localparam logic [2:0] OP_READ_V  = 3'd0;
   localparam logic [2:0] OP_READ_I  = 3'd1;
   localparam logic [2:0] OP_WRITE   = 3'd2;
   localparam logic [2:0] OP_ALL_V   = 3'd3;
   localparam logic [2:0] OP_ALL_I   = 3'd4;

   localparam logic [1:0] PHASE_SIGN   = 2'd0;
   localparam logic [1:0] PHASE_DIGITS = 2'd1;
   localparam logic [1:0] PHASE_DONE   = 2'd2;

   localparam logic [16:0] MAG_SAT = 17'd65536;

   localparam logic CSR_VALUE_MIN = 1'b0;
   localparam logic CSR_VALUE_MAX = 1'b1;

   // Upper-case fold of ASCII letters
   function automatic logic [7:0] fold(input logic [7:0] c);
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
         return c - 8'd32;
      end
      return c;
   endfunction

endpackage

// ===== src/gclp_if.sv =====
// Valid/ready channel interfaces for request characters and line results.
// No dependencies.
`timescale 1ns / 1ps

interface gclp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface gclp_rsp_if;
   logic        valid;
   logic        ready;
   logic        rejected;
   logic [2:0]  op_code;
   logic [2:0]  grid_x;
   logic [2:0]  grid_y;
   logic [15:0] out_value;

   modport source (output valid, output rejected, output op_code, output grid_x,
                   output grid_y, output out_value, input ready);
   modport sink   (input valid, input rejected, input op_code, input grid_x,
                   input grid_y, input out_value, output ready);
endinterface

// ===== src/grid_command_line_parser.sv =====
// Grid command line parser.
// Channels: req carries one character per word (char_in); rsp carries one
// word per line end: rejected, op_code, grid_x, grid_y and out_value.
// Lines are R,V|I,x,y,value / W,I,x,y,value / P,V|I, comma separated,
// spaces stripped, letters case-insensitive, newline (10) ends a line.
// csr_write_en/csr_index/csr_data write value_min (index 0) and
// value_max (index 1); write them only while the parser is idle.
// The result word for a newline appears on rsp in the cycle after the newline
// is accepted. Throughput: one character per cycle while req is ready; every
// character is fully handled by combinational logic ahead of the state
// and output registers.
// A pending result sits in the rsp output register; req stays ready while
// that register is empty or being drained this cycle, so a stalled rsp side
// stalls req for every character as long as a result word is waiting.
// Reset (synchronous, active high) returns to the start of a line, clears
// the held instruction fields and sets value_min 0, value_max 65535.
// Depends on gclp_pkg, gclp_if and gclp_token.
`timescale 1ns / 1ps

module grid_command_line_parser #(
   parameter int GRID_HIGH = 5
) (
   input  logic        clock,
   input  logic        reset,
   gclp_req_if.sink    req,
   gclp_rsp_if.source  rsp,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import gclp_pkg::*;

   localparam logic [7:0] GRID_TOP = 8'(48 + GRID_HIGH);

   logic [15:0] value_min_ff, value_max_ff;

   logic [2:0]  field_ff, field_in;
   logic [1:0]  kind_ff, kind_in;
   logic        failed_ff, failed_in;
   logic [2:0]  held_op_ff, held_op_in;
   logic [2:0]  held_x_ff, held_x_in;
   logic [2:0]  held_y_ff, held_y_in;
   logic [15:0] held_value_ff, held_value_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rejected_ff;

   logic        accept;
   logic        is_comma;
   logic        is_newline;
   logic        finish;
   logic        done;
   logic        fail;
   logic        one_r, one_w, one_p, one_v, one_i;
   logic        grid_ok;
   tok_status_type tok;

   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign accept     = req.valid && req.ready;
   assign is_comma   = (req.char_in == CHAR_COMMA);
   assign is_newline = (req.char_in == CHAR_NEWLINE);

   gclp_token u_token (
      .clock       (clock),
      .reset       (reset),
      .take        (accept && !is_comma && !is_newline),
      .clear       (accept && (is_comma || is_newline)),
      .value_field (field_ff == FIELD_VALUE),
      .char_in     (req.char_in),
      .status      (tok)
   );

   assign one_r = (tok.nonspace_count == 2'd1) && (fold(tok.first_char) == CHAR_R);
   assign one_w = (tok.nonspace_count == 2'd1) && (fold(tok.first_char) == CHAR_W);
   assign one_p = (tok.nonspace_count == 2'd1) && (fold(tok.first_char) == CHAR_P);
   assign one_v = (tok.nonspace_count == 2'd1) && (fold(tok.first_char) == CHAR_V);
   assign one_i = (tok.nonspace_count == 2'd1) && (fold(tok.first_char) == CHAR_I);
   assign grid_ok = (tok.nonspace_count == 2'd1) && (tok.first_char >= CHAR_ONE) &&
                    (tok.first_char <= GRID_TOP);

   // Empty fields between commas are skipped; a line end closes a field unless the line has already failed.
   assign finish = accept && !failed_ff && ((is_comma && tok.nonempty) || is_newline);

   always_comb begin
      field_in      = field_ff;
      kind_in       = kind_ff;
      held_op_in    = held_op_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      held_value_in = held_value_ff;
      done          = 1'b0;
      fail          = 1'b0;
      if (finish) begin
         unique case (field_ff)
            FIELD_CMD: begin
               if (!is_newline && one_r) begin
                  kind_in = KIND_READ;
               end else if (!is_newline && one_w) begin
                  kind_in = KIND_WRITE;
               end else if (!is_newline && one_p) begin
                  kind_in = KIND_ALL;
               end else begin
                  fail = 1'b1;
               end
               field_in = FIELD_SPEC;
            end
            FIELD_SPEC: begin
               if (kind_ff == KIND_READ) begin
                  if (!is_newline && one_v) begin
                     held_op_in = OP_READ_V;
                     field_in   = FIELD_X;
                  end else if (!is_newline && one_i) begin
                     held_op_in = OP_READ_I;
                     field_in   = FIELD_X;
                  end else begin
                     fail = 1'b1;
                  end
               end else if (kind_ff == KIND_WRITE) begin
                  if (!is_newline && one_i) begin
                     held_op_in = OP_WRITE;
                     field_in   = FIELD_X;
                  end else begin
                     fail = 1'b1;
                  end
               end else begin
                  if (is_newline && one_v) begin
                     held_op_in = OP_ALL_V;
                     done       = 1'b1;
                  end else if (is_newline && one_i) begin
                     held_op_in = OP_ALL_I;
                     done       = 1'b1;
                  end else begin
                     fail = 1'b1;
                  end
               end
            end
            FIELD_X, FIELD_Y: begin
               if (!is_newline && grid_ok) begin
                  // '0' has zero low bits, so the digit value is the low 3 bits
                  if (field_ff == FIELD_X) begin
                     held_x_in = tok.first_char[2:0];
                  end else begin
                     held_y_in = tok.first_char[2:0];
                  end
                  field_in = field_ff + 3'd1;
               end else begin
                  fail = 1'b1;
               end
            end
            FIELD_VALUE: begin
               if (!is_newline || tok.nonspace_count == 2'd0) begin
                  fail = 1'b1;
               end else if (tok.negative && tok.magnitude != 17'd0) begin
                  fail = 1'b1;
               end else if (tok.magnitude < {1'b0, value_min_ff} ||
                            tok.magnitude > {1'b0, value_max_ff}) begin
                  fail = 1'b1;
               end else begin
                  held_value_in = tok.magnitude[15:0];
                  done          = 1'b1;
               end
            end
            default: begin
               fail = 1'b1;
            end
         endcase
      end
      failed_in = failed_ff || fail;
      if (accept && is_newline) begin
         field_in  = FIELD_CMD;
         kind_in   = KIND_READ;
         failed_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (accept && is_newline) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_min_ff  <= 16'd0;
         value_max_ff  <= 16'hFFFF;
         field_ff      <= FIELD_CMD;
         kind_ff       <= KIND_READ;
         failed_ff     <= 1'b0;
         held_op_ff    <= OP_READ_V;
         held_x_ff     <= 3'd0;
         held_y_ff     <= 3'd0;
         held_value_ff <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en && csr_index == CSR_VALUE_MIN) begin
            value_min_ff <= csr_data;
         end
         if (csr_write_en && csr_index == CSR_VALUE_MAX) begin
            value_max_ff <= csr_data;
         end
         field_ff      <= field_in;
         kind_ff       <= kind_in;
         failed_ff     <= failed_in;
         held_op_ff    <= held_op_in;
         held_x_ff     <= held_x_in;
         held_y_ff     <= held_y_in;
         held_value_ff <= held_value_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result word payload; held fields are the registers themselves
   always_ff @(posedge clock) begin
      if (accept && is_newline) begin
         rejected_ff <= !(done && !failed_ff);
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.rejected  = rejected_ff;
   assign rsp.op_code   = held_op_ff;
   assign rsp.grid_x    = held_x_ff;
   assign rsp.grid_y    = held_y_ff;
   assign rsp.out_value = held_value_ff;

endmodule

// ===== src/gclp_token.sv =====
// Field collector: tracks non-space count, first character and the atoi-style number.
// Depends on gclp_pkg.
`timescale 1ns / 1ps

module gclp_token (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic                   clear,
   input  logic                   value_field,
   input  logic [7:0]             char_in,
   output gclp_pkg::tok_status_type status
);
   import gclp_pkg::*;

   logic        nonempty_ff, nonempty_in;
   logic [1:0]  count_ff, count_in;
   logic [7:0]  first_ff, first_in;
   logic [1:0]  phase_ff, phase_in;
   logic        neg_ff, neg_in;
   logic [16:0] mag_ff, mag_in;

   logic        is_digit;
   logic        is_ws;
   logic        is_sign;
   logic        acc;
   logic [19:0] product;

   assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
   assign is_ws    = (char_in == CHAR_TAB) || (char_in == CHAR_VTAB) ||
                     (char_in == CHAR_FFEED) || (char_in == CHAR_CR);
   assign is_sign  = (char_in == CHAR_PLUS) || (char_in == CHAR_MINUS);
   // mag * 10 + digit
   assign product  = {mag_ff, 3'b000} + {2'b00, mag_ff, 1'b0} +
                     {16'd0, (char_in[3:0] & {4{is_digit}})};

   always_comb begin
      nonempty_in = nonempty_ff;
      count_in    = count_ff;
      first_in    = first_ff;
      phase_in    = phase_ff;
      neg_in      = neg_ff;
      mag_in      = mag_ff;
      acc         = 1'b0;
      if (clear) begin
         nonempty_in = 1'b0;
         count_in    = 2'd0;
         first_in    = 8'd0;
         phase_in    = PHASE_SIGN;
         neg_in      = 1'b0;
         mag_in      = 17'd0;
      end else if (take) begin
         nonempty_in = 1'b1;
         if (char_in != CHAR_SPACE) begin
            if (count_ff == 2'd0) begin
               first_in = char_in;
            end
            if (count_ff != 2'd2) begin
               count_in = count_ff + 2'd1;
            end
            if (value_field) begin
               unique case (phase_ff)
                  PHASE_SIGN: begin
                     if (is_ws) begin
                        phase_in = PHASE_SIGN;
                     end else if (is_sign) begin
                        neg_in   = (char_in == CHAR_MINUS);
                        phase_in = PHASE_DIGITS;
                     end else begin
                        phase_in = is_digit ? PHASE_DIGITS : PHASE_DONE;
                        acc      = is_digit;
                     end
                  end
                  PHASE_DIGITS: begin
                     if (is_digit) begin
                        acc = 1'b1;
                     end else begin
                        phase_in = PHASE_DONE;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
               if (acc) begin
                  mag_in = (product > {3'b000, MAG_SAT}) ? MAG_SAT : product[16:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= 1'b0;
         count_ff    <= 2'd0;
         first_ff    <= 8'd0;
         phase_ff    <= PHASE_SIGN;
         neg_ff      <= 1'b0;
         mag_ff      <= 17'd0;
      end else begin
         nonempty_ff <= nonempty_in;
         count_ff    <= count_in;
         first_ff    <= first_in;
         phase_ff    <= phase_in;
         neg_ff      <= neg_in;
         mag_ff      <= mag_in;
      end
   end

   assign status.nonempty       = nonempty_ff;
   assign status.nonspace_count = count_ff;
   assign status.first_char     = first_ff;
   assign status.negative       = neg_ff;
   assign status.magnitude      = mag_ff;

endmodule

// ===== bench/grid_command_line_parser_tb.sv =====
// Self-checking testbench for grid_command_line_parser: random command lines, a
// line-level predictor and a scoreboard that checks every result word in order.
// Depends on gclp_pkg, gclp_if and the parser RTL.
`timescale 1ns / 1ps

module grid_command_line_parser_tb;
   import gclp_pkg::*;

   localparam int GRID_MAX    = 5;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int SEG_CHARS   = 100;
   localparam int NUM_SEGS    = 6;

   typedef struct packed {
      logic        rejected;
      logic [2:0]  op_code;
      logic [2:0]  grid_x;
      logic [2:0]  grid_y;
      logic [15:0] out_value;
   } line_word_type;

   // Predicts the status word of each line end and checks the words coming back
   class line_scoreboard_type;
      bit [15:0]   lim_min;
      bit [15:0]   lim_max;
      bit [2:0]    fld;
      bit [1:0]    kind;
      bit          failed;
      bit          nonempty;
      bit [1:0]    ns_count;
      bit [7:0]    first_ch;
      bit [1:0]    num_phase;
      bit          neg;
      int unsigned mag;
      bit [2:0]    h_op;
      bit [2:0]    h_x;
      bit [2:0]    h_y;
      bit [15:0]   h_val;
      line_word_type pending[$];
      int          errors;

      function new();
         lim_min = 16'd0;
         lim_max = 16'hFFFF;
         h_op = OP_READ_V;
         h_x = 3'd0;
         h_y = 3'd0;
         h_val = 16'd0;
         errors = 0;
         clear_line();
      endfunction

      function void set_limit(logic idx, bit [15:0] v);
         if (idx == CSR_VALUE_MIN) begin
            lim_min = v;
         end else begin
            lim_max = v;
         end
      endfunction

      function void clear_token();
         nonempty = 1'b0;
         ns_count = 2'd0;
         first_ch = 8'd0;
         num_phase = PHASE_SIGN;
         neg = 1'b0;
         mag = 0;
      endfunction

      function void clear_line();
         fld = FIELD_CMD;
         kind = KIND_READ;
         failed = 1'b0;
         clear_token();
      endfunction

      function bit single_letter(bit [7:0] up);
         return ns_count == 2'd1 && (first_ch == up || first_ch == up + 8'd32);
      endfunction

      function void number_char(bit [7:0] c);
         bit digit;
         int unsigned acc;
         digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
         if (num_phase == PHASE_SIGN) begin
            // atoi skips leading white space other than plain space (already dropped)
            if (c == CHAR_TAB || c == CHAR_VTAB || c == CHAR_FFEED || c == CHAR_CR) return;
            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               neg = (c == CHAR_MINUS);
               num_phase = PHASE_DIGITS;
               return;
            end
            num_phase = digit ? PHASE_DIGITS : PHASE_DONE;
         end else if (num_phase == PHASE_DIGITS && !digit) begin
            num_phase = PHASE_DONE;
         end
         if (num_phase == PHASE_DIGITS && digit) begin
            acc = mag * 10 + (c - CHAR_ZERO);
            mag = (acc > 65536) ? 65536 : acc;
         end
      endfunction

      function void take_char(bit [7:0] c);
         nonempty = 1'b1;
         if (c == CHAR_SPACE) return;
         if (ns_count == 2'd0) first_ch = c;
         if (ns_count < 2'd2) ns_count++;
         if (fld == FIELD_VALUE) number_char(c);
      endfunction

      // closes the current field, returns 1 when the line is complete and good
      function bit close_field(bit at_end);
         bit done;
         done = 1'b0;
         case (fld)
            FIELD_CMD: begin
               if (!at_end && single_letter(CHAR_R)) kind = KIND_READ;
               else if (!at_end && single_letter(CHAR_W)) kind = KIND_WRITE;
               else if (!at_end && single_letter(CHAR_P)) kind = KIND_ALL;
               else failed = 1'b1;
               fld = FIELD_SPEC;
            end
            FIELD_SPEC: begin
               if (kind == KIND_READ) begin
                  if (!at_end && single_letter(CHAR_V)) begin
                     h_op = OP_READ_V;
                     fld = FIELD_X;
                  end else if (!at_end && single_letter(CHAR_I)) begin
                     h_op = OP_READ_I;
                     fld = FIELD_X;
                  end else begin
                     failed = 1'b1;
                  end
               end else if (kind == KIND_WRITE) begin
                  if (!at_end && single_letter(CHAR_I)) begin
                     h_op = OP_WRITE;
                     fld = FIELD_X;
                  end else begin
                     failed = 1'b1;
                  end
               end else begin
                  if (at_end && single_letter(CHAR_V)) begin
                     h_op = OP_ALL_V;
                     done = 1'b1;
                  end else if (at_end && single_letter(CHAR_I)) begin
                     h_op = OP_ALL_I;
                     done = 1'b1;
                  end else begin
                     failed = 1'b1;
                  end
               end
            end
            FIELD_X, FIELD_Y: begin
               if (!at_end && ns_count == 2'd1 && first_ch >= CHAR_ONE &&
                   first_ch <= CHAR_ZERO + GRID_MAX) begin
                  if (fld == FIELD_X) h_x = 3'(first_ch - CHAR_ZERO);
                  else h_y = 3'(first_ch - CHAR_ZERO);
                  fld = fld + 3'd1;
               end else begin
                  failed = 1'b1;
               end
            end
            FIELD_VALUE: begin
               if (!at_end || ns_count == 2'd0) failed = 1'b1;
               else if (neg && mag != 0) failed = 1'b1;
               else if (mag < lim_min || mag > lim_max) failed = 1'b1;
               else begin
                  h_val = 16'(mag);
                  done = 1'b1;
               end
            end
            default: failed = 1'b1;
         endcase
         return done && !failed;
      endfunction

      function void note_char(bit [7:0] c);
         bit ok;
         if (c == CHAR_COMMA) begin
            if (nonempty && !failed) void'(close_field(1'b0));
            clear_token();
            return;
         end
         if (c != CHAR_NEWLINE) begin
            take_char(c);
            return;
         end
         ok = 1'b0;
         if (!failed) ok = close_field(1'b1);
         pending.push_back(line_word_type'({~ok, h_op, h_x, h_y, h_val}));
         clear_line();
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_word(line_word_type got);
         line_word_type want;
         if (pending.size() == 0) begin
            report($sformatf("result word %h with no line end pending", got));
            return;
         end
         want = pending.pop_front();
         if (got.rejected !== want.rejected)
            report($sformatf("rejected %b, expected %b", got.rejected, want.rejected));
         if (got.op_code !== want.op_code)
            report($sformatf("op_code %0d, expected %0d", got.op_code, want.op_code));
         if (got.grid_x !== want.grid_x)
            report($sformatf("grid_x %0d, expected %0d", got.grid_x, want.grid_x));
         if (got.grid_y !== want.grid_y)
            report($sformatf("grid_y %0d, expected %0d", got.grid_y, want.grid_y));
         if (got.out_value !== want.out_value)
            report($sformatf("out_value %0d, expected %0d", got.out_value, want.out_value));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_en;
   logic        csr_index;
   logic [15:0] csr_data;

   gclp_req_if req_ch ();
   gclp_rsp_if rsp_ch ();

   grid_command_line_parser #(
      .GRID_HIGH(GRID_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   line_scoreboard_type sb;
   bit [7:0]       line_buf[$];
   int             cur_min = 0;
   int             cur_max = 65535;
   int             send_idle_pct;
   int             recv_idle_pct;
   int             sent_count = 0;
   int             stall_cycles = 0;
   int             hold_left = 0;
   bit             want_hold = 1'b0;
   int             lim_lo [NUM_SEGS] = '{0, 100, 65535, 0, 500, 0};
   int             lim_hi [NUM_SEGS] = '{65535, 200, 65535, 0, 100, 65535};
   string          directed [3] = '{"p,I\n", "w,i,5,1,-0\n", "R,V,,1, ,\n"};

   always #4 clock = ~clock;

   // result side: random back-pressure plus one long hold-off on request
   always @(negedge clock) begin
      if (want_hold) begin
         want_hold = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_char(req_ch.char_in);
            sent_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_word(line_word_type'({rsp_ch.rejected, rsp_ch.op_code, rsp_ch.grid_x,
                                           rsp_ch.grid_y, rsp_ch.out_value}));
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic bit [7:0] any_case(bit [7:0] up);
      return ($urandom_range(1) == 1) ? up + 8'd32 : up;
   endfunction

   function automatic void add_char(bit [7:0] c);
      if ($urandom_range(9) == 0) line_buf.push_back(CHAR_SPACE);
      line_buf.push_back(c);
      if ($urandom_range(9) == 0) line_buf.push_back(CHAR_SPACE);
   endfunction

   function automatic void add_comma();
      line_buf.push_back(CHAR_COMMA);
      if ($urandom_range(7) == 0) line_buf.push_back(CHAR_COMMA);
   endfunction

   function automatic bit [7:0] grid_char();
      int r;
      r = $urandom_range(19);
      if (r < 16) return CHAR_ZERO + 8'($urandom_range(GRID_MAX, 1));
      if (r == 16) return CHAR_ZERO;
      return CHAR_ZERO + 8'($urandom_range(9, GRID_MAX + 1));
   endfunction

   function automatic void add_value();
      int    n;
      string s;
      bit [7:0] ws [4];
      ws = '{CHAR_TAB, CHAR_VTAB, CHAR_FFEED, CHAR_CR};
      if ($urandom_range(19) == 0) begin
         // value field with nothing but spaces
         repeat ($urandom_range(2)) line_buf.push_back(CHAR_SPACE);
         return;
      end
      case ($urandom_range(11))
         0:       n = cur_min;
         1:       n = cur_max;
         2:       n = cur_min - 1;
         3:       n = cur_max + 1;
         4:       n = 0;
         5:       n = $urandom_range(999999, 65536);
         6, 7, 8: n = $urandom_range(cur_max, cur_min);
         default: n = $urandom_range(65535);
      endcase
      if (n < 0) n = 0;
      case ($urandom_range(7))
         0: line_buf.push_back(ws[$urandom_range(3)]);
         1: line_buf.push_back(CHAR_SPACE);
         default: ;
      endcase
      case ($urandom_range(5))
         0: line_buf.push_back(CHAR_PLUS);
         1: line_buf.push_back(CHAR_MINUS);
         default: ;
      endcase
      if ($urandom_range(9) == 0) line_buf.push_back(CHAR_ZERO);
      s = $sformatf("%0d", n);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
      if ($urandom_range(7) == 0) begin
         // trailing junk stops the number
         line_buf.push_back(8'($urandom_range(126, 58)));
         line_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      end
   endfunction

   function automatic void build_line();
      int style;
      int kind;
      int pos;
      bit spec_v;
      line_buf.delete();
      style = $urandom_range(99);
      if (style < 10) begin
         repeat ($urandom_range(12, 1)) line_buf.push_back(8'($urandom_range(255)));
         line_buf.push_back(CHAR_NEWLINE);
         return;
      end
      if ($urandom_range(9) == 0) line_buf.push_back(CHAR_COMMA);
      kind = $urandom_range(2);
      add_char(any_case(kind == 0 ? CHAR_R : (kind == 1 ? CHAR_W : CHAR_P)));
      add_comma();
      if (kind == 1) spec_v = ($urandom_range(4) == 0);
      else spec_v = ($urandom_range(1) == 1);
      add_char(any_case(spec_v ? CHAR_V : CHAR_I));
      if (kind != 2) begin
         add_comma();
         add_char(grid_char());
         add_comma();
         add_char(grid_char());
         add_comma();
         add_value();
      end
      line_buf.push_back(CHAR_NEWLINE);
      if (style < 25) begin
         pos = $urandom_range(line_buf.size() - 2);
         case ($urandom_range(4))
            0: line_buf[pos] = 8'($urandom_range(255));
            1: line_buf.insert(line_buf.size() - 1, CHAR_COMMA);
            2: line_buf.delete(pos);
            3: begin
               line_buf.insert(pos, CHAR_COMMA);
               line_buf.insert(pos, CHAR_SPACE);
               line_buf.insert(pos, CHAR_COMMA);
            end
            default: begin
               // line ends early, inside whatever field pos falls in
               while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
               line_buf.push_back(CHAR_NEWLINE);
            end
         endcase
      end
   endfunction

   task automatic send_char(input bit [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.char_in <= c;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
   endtask

   // wait for every line end to be answered, then let the pipeline drain
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input int v);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= 16'(v);
      @(negedge clock);
      csr_write_en <= 1'b0;
      sb.set_limit(idx, 16'(v));
      if (idx == CSR_VALUE_MIN) cur_min = v;
      else cur_max = v;
      @(negedge clock);
   endtask

   initial begin
      int seg_start;
      sb = new();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.char_in = 8'd0;
      rsp_ch.ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_VALUE_MIN;
      csr_data = 16'd0;
      send_idle_pct = 34;
      recv_idle_pct = 75;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int seg = 0; seg < NUM_SEGS; seg++) begin
         case (seg / 2)
            0: begin
               send_idle_pct = 34;
               recv_idle_pct = 75;
            end
            1: begin
               send_idle_pct = 75;
               recv_idle_pct = 34;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (seg == 0) begin
            foreach (directed[i])
               for (int j = 0; j < directed[i].len(); j++) send_char(directed[i][j]);
         end else begin
            settle();
            write_csr(CSR_VALUE_MIN, lim_lo[seg]);
            write_csr(CSR_VALUE_MAX, lim_hi[seg]);
         end
         // long result stall with a full-rate sender: the parser must stall req
         if (seg == NUM_SEGS - 1) want_hold = 1'b1;
         seg_start = sent_count;
         while (sent_count - seg_start < SEG_CHARS) begin
            build_line();
            foreach (line_buf[i]) send_char(line_buf[i]);
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/gclp_pkg.sv
src/gclp_if.sv
src/gclp_token.sv
src/grid_command_line_parser.sv
bench/grid_command_line_parser_tb.sv
